/* src/ebc_pkg.sv */
package ebc_pkg;

    localparam int VW          = 32;
    localparam int CW          = $clog2(VW);
    localparam int ERR_W       = 3;
    localparam int OUT_TDATA_W = ((VW + ERR_W + 7) / 8) * 8;
    localparam int APB_AW      = 5;
    localparam int APB_DW      = 32;

    localparam logic [VW-1:0] BYTE_MAX = VW'(255);
    localparam logic [VW-1:0] P_RESET  = VW'(64'd4294967291);
    localparam logic [VW-1:0] G_RESET  = VW'(2);
    localparam logic [VW-1:0] A_RESET  = VW'(1);
    localparam logic [VW-1:0] K_RESET  = VW'(1);

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 3'd0,
        ERR_KEY   = 3'd1,
        ERR_RANGE = 3'd2,
        ERR_BYTE  = 3'd3,
        ERR_NOKEY = 3'd4
    } t_err;

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_DATA  = 1'b1
    } t_func;

    typedef enum logic {
        MODE_ENC = 1'b0,
        MODE_DEC = 1'b1
    } t_mode;

    typedef enum logic [2:0] {
        REG_MODE = 3'd0,
        REG_PRIME = 3'd1,
        REG_GEN  = 3'd2,
        REG_PKEY = 3'd3,
        REG_SKEY = 3'd4
    } t_reg;

    typedef enum logic [2:0] {
        SRC_ONE  = 3'd0,
        SRC_G    = 3'd1,
        SRC_V    = 3'd2,
        SRC_BASE = 3'd3,
        SRC_PACC = 3'd4,
        SRC_KEY  = 3'd5
    } t_src;

    typedef enum logic [1:0] {
        EXP_A   = 2'd0,
        EXP_K   = 2'd1,
        EXP_DEC = 2'd2
    } t_exp_sel;

    typedef enum logic [1:0] {
        DST_NONE = 2'd0,
        DST_BASE = 2'd1,
        DST_PACC = 2'd2
    } t_dst;

    typedef enum logic [1:0] {
        OSEL_ZERO = 2'd0,
        OSEL_HDR  = 2'd1,
        OSEL_PROD = 2'd2
    } t_osel;

    typedef struct packed {
        t_mode         mode;
        logic [VW-1:0] p;
        logic [VW-1:0] g;
        logic [VW-1:0] a;
        logic [VW-1:0] k;
    } t_cfg;

    typedef struct packed {
        logic     take;
        logic     mm_go;
        t_src     mcand_sel;
        t_src     mplier_sel;
        t_dst     dst;
        logic     exp_ld;
        t_exp_sel exp_sel;
        logic     exp_shift;
        logic     pacc_init;
        logic     key_ld;
        logic     hdr_ld;
        logic     out_ld;
        t_osel    out_sel;
        t_err     out_err;
    } t_cmd;

    typedef struct packed {
        logic mm_busy;
        logic mm_done;
        logic a_ok;
        logic k_ok;
        logic val_lt_p;
        logic val_byte;
        logic prod_byte;
        logic exp_zero;
        logic exp_lsb;
    } t_sts;

endpackage

/* src/ebc_dpath.sv */
module ebc_dpath import ebc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic [VW-1:0]          i_value,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    output logic [VW-1:0]          o_out_value,
    output t_err                   o_out_err
);

    logic [VW-1:0] r_val;
    logic [VW-1:0] r_acc;
    logic [VW-1:0] r_mcand;
    logic [VW-1:0] r_mplier;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [VW-1:0] r_base;
    logic [VW-1:0] r_pacc;
    logic [VW-1:0] r_exp;
    logic [VW-1:0] r_key;
    logic [VW-1:0] r_hdr;
    logic [VW-1:0] r_out_value;
    t_err          r_out_err;

    logic [VW+1:0] w_t;
    logic [VW+1:0] w_p1;
    logic [VW+1:0] w_p2;
    logic [VW+1:0] w_step;
    logic [VW-1:0] w_next;
    logic [VW-1:0] w_mcand_src;
    logic [VW-1:0] w_mplier_src;
    logic [VW-1:0] w_exp_src;
    logic [VW-1:0] w_out_src;
    logic          w_done;

    function automatic logic [VW-1:0] pick_src(
        input t_src          sel,
        input logic [VW-1:0] g,
        input logic [VW-1:0] v,
        input logic [VW-1:0] base,
        input logic [VW-1:0] pacc,
        input logic [VW-1:0] key
    );
        logic [VW-1:0] res;
        case (sel)
            SRC_ONE:  res = VW'(1);
            SRC_G:    res = g;
            SRC_V:    res = v;
            SRC_BASE: res = base;
            SRC_PACC: res = pacc;
            SRC_KEY:  res = key;
            default:  res = '0;
        endcase
        return res;
    endfunction

    // One step of the interleaved modular multiply, multiplier scanned from its top bit.
    // With acc and multiplicand below p, 2*acc + mcand stays below 3p.
    always_comb begin
        w_t  = {1'b0, r_acc, 1'b0} + (r_mplier[VW-1] ? {2'b00, r_mcand} : '0);
        w_p1 = {2'b00, i_cfg.p};
        w_p2 = {1'b0, i_cfg.p, 1'b0};
        if (w_t >= w_p2) begin
            w_step = w_t - w_p2;
        end else if (w_t >= w_p1) begin
            w_step = w_t - w_p1;
        end else begin
            w_step = w_t;
        end
        w_next = w_step[VW-1:0];
    end

    assign w_done = r_busy && (r_cnt == CW'(VW - 1));

    always_comb begin
        w_mcand_src  = pick_src(i_cmd.mcand_sel, i_cfg.g, r_val, r_base, r_pacc, r_key);
        w_mplier_src = pick_src(i_cmd.mplier_sel, i_cfg.g, r_val, r_base, r_pacc, r_key);
    end

    always_comb begin
        case (i_cmd.exp_sel)
            EXP_A:   w_exp_src = i_cfg.a;
            EXP_K:   w_exp_src = i_cfg.k;
            EXP_DEC: w_exp_src = i_cfg.p - VW'(1) - i_cfg.a;
            default: w_exp_src = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.out_sel)
            OSEL_HDR:  w_out_src = r_hdr;
            OSEL_PROD: w_out_src = r_acc;
            default:   w_out_src = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.mm_go) begin
            r_busy <= 1'b1;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_val <= i_value;
        end
        if (i_cmd.mm_go) begin
            r_acc    <= '0;
            r_mcand  <= w_mcand_src;
            r_mplier <= w_mplier_src;
            r_cnt    <= '0;
        end else if (r_busy) begin
            r_acc    <= w_next;
            r_mplier <= {r_mplier[VW-2:0], 1'b0};
            r_cnt    <= r_cnt + CW'(1);
        end
        if (i_cmd.pacc_init) begin
            r_pacc <= VW'(1);
        end
        if (w_done) begin
            case (i_cmd.dst)
                DST_BASE: r_base <= w_next;
                DST_PACC: r_pacc <= w_next;
                default:  ;
            endcase
        end
        if (i_cmd.exp_ld) begin
            r_exp <= w_exp_src;
        end else if (i_cmd.exp_shift) begin
            r_exp <= {1'b0, r_exp[VW-1:1]};
        end
        if (i_cmd.key_ld) begin
            r_key <= r_pacc;
        end
        if (i_cmd.hdr_ld) begin
            r_hdr <= r_pacc;
        end
        if (i_cmd.out_ld) begin
            r_out_value <= w_out_src;
            r_out_err   <= i_cmd.out_err;
        end
    end

    // A key is valid when 1 <= x and x + 2 <= p.
    always_comb begin
        o_sts.mm_busy   = r_busy;
        o_sts.mm_done   = w_done;
        o_sts.a_ok      = (i_cfg.a != '0) &&
                          (({1'b0, i_cfg.a} + (VW+1)'(2)) <= {1'b0, i_cfg.p});
        o_sts.k_ok      = (i_cfg.k != '0) &&
                          (({1'b0, i_cfg.k} + (VW+1)'(2)) <= {1'b0, i_cfg.p});
        o_sts.val_lt_p  = r_val < i_cfg.p;
        o_sts.val_byte  = r_val <= BYTE_MAX;
        o_sts.prod_byte = r_acc <= BYTE_MAX;
        o_sts.exp_zero  = r_exp == '0;
        o_sts.exp_lsb   = r_exp[0];
    end

    assign o_out_value = r_out_value;
    assign o_out_err   = r_out_err;

`ifndef NO_ASSERTIONS
    a_mm_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> (r_acc < i_cfg.p))
        else $error("modular multiply result not below modulus");
`endif

endmodule

/* src/ebc_ctrl.sv */
module ebc_ctrl import ebc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_mode i_mode,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    input  t_func i_s_func,
    output logic  o_m_tvalid,
    input  logic  i_m_tready,
    input  t_sts  i_sts,
    output t_cmd  o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_CHECK  = 11'b00000000010,
        S_PSTART = 11'b00000000100,
        S_BLOAD  = 11'b00000001000,
        S_ETEST  = 11'b00000010000,
        S_EMUL   = 11'b00000100000,
        S_ESQG   = 11'b00001000000,
        S_ESQR   = 11'b00010000000,
        S_DMUL   = 11'b00100000000,
        S_DFIN   = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } t_state;

    // Which exponentiation of a start word is running.
    typedef enum logic [1:0] {
        PH_ENC0 = 2'd0,
        PH_ENC1 = 2'd1,
        PH_ENC2 = 2'd2,
        PH_DEC  = 2'd3
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    t_func  r_func, n_func;
    logic   r_key_ready, n_key_ready;
    logic   r_ovalid, n_ovalid;
    t_err   r_err, n_err;
    t_osel  r_osel, n_osel;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_func      = r_func;
        n_key_ready = r_key_ready;
        n_ovalid    = r_ovalid;
        n_err       = r_err;
        n_osel      = r_osel;
        o_cmd       = '0;
        o_cmd.out_err = r_err;
        o_cmd.out_sel = r_osel;

        if (i_m_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.take = 1'b1;
                    n_func     = i_s_func;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_func == FUNC_START) begin
                    if (!i_sts.a_ok || (i_mode == MODE_ENC && !i_sts.k_ok)) begin
                        n_key_ready = 1'b0;
                        n_err       = ERR_KEY;
                        n_osel      = OSEL_ZERO;
                        n_state     = S_OUT;
                    end else begin
                        n_phase = (i_mode == MODE_ENC) ? PH_ENC0 : PH_DEC;
                        n_state = S_PSTART;
                    end
                end else begin
                    n_osel  = OSEL_ZERO;
                    n_state = S_OUT;
                    if (!r_key_ready) begin
                        n_err = ERR_NOKEY;
                    end else if (!i_sts.val_lt_p) begin
                        n_err = ERR_RANGE;
                    end else if (i_mode == MODE_ENC && !i_sts.val_byte) begin
                        n_err = ERR_BYTE;
                    end else begin
                        o_cmd.mm_go      = 1'b1;
                        o_cmd.mcand_sel  = SRC_V;
                        o_cmd.mplier_sel = SRC_KEY;
                        n_state          = S_DMUL;
                    end
                end
            end
            S_PSTART: begin
                // Reduce the base mod p by multiplying it by one.
                o_cmd.mm_go     = 1'b1;
                o_cmd.mcand_sel = SRC_ONE;
                o_cmd.exp_ld    = 1'b1;
                o_cmd.pacc_init = 1'b1;
                case (r_phase)
                    PH_ENC0: begin
                        o_cmd.mplier_sel = SRC_G;
                        o_cmd.exp_sel    = EXP_K;
                    end
                    PH_ENC1: begin
                        o_cmd.mplier_sel = SRC_G;
                        o_cmd.exp_sel    = EXP_A;
                    end
                    PH_ENC2: begin
                        o_cmd.mplier_sel = SRC_PACC;
                        o_cmd.exp_sel    = EXP_K;
                    end
                    default: begin
                        o_cmd.mplier_sel = SRC_V;
                        o_cmd.exp_sel    = EXP_DEC;
                    end
                endcase
                n_state = S_BLOAD;
            end
            S_BLOAD: begin
                o_cmd.dst = DST_BASE;
                if (i_sts.mm_done) begin
                    n_state = S_ETEST;
                end
            end
            S_ETEST: begin
                if (i_sts.exp_zero) begin
                    case (r_phase)
                        PH_ENC0: begin
                            o_cmd.hdr_ld = 1'b1;
                            n_phase      = PH_ENC1;
                            n_state      = S_PSTART;
                        end
                        PH_ENC1: begin
                            n_phase = PH_ENC2;
                            n_state = S_PSTART;
                        end
                        default: begin
                            o_cmd.key_ld = 1'b1;
                            n_key_ready  = 1'b1;
                            n_err        = ERR_OK;
                            n_osel       = (r_phase == PH_ENC2) ? OSEL_HDR : OSEL_ZERO;
                            n_state      = S_OUT;
                        end
                    endcase
                end else if (i_sts.exp_lsb) begin
                    o_cmd.mm_go      = 1'b1;
                    o_cmd.mcand_sel  = SRC_PACC;
                    o_cmd.mplier_sel = SRC_BASE;
                    n_state          = S_EMUL;
                end else begin
                    n_state = S_ESQG;
                end
            end
            S_EMUL: begin
                o_cmd.dst = DST_PACC;
                if (i_sts.mm_done) begin
                    n_state = S_ESQG;
                end
            end
            S_ESQG: begin
                o_cmd.mm_go      = 1'b1;
                o_cmd.mcand_sel  = SRC_BASE;
                o_cmd.mplier_sel = SRC_BASE;
                o_cmd.exp_shift  = 1'b1;
                n_state          = S_ESQR;
            end
            S_ESQR: begin
                o_cmd.dst = DST_BASE;
                if (i_sts.mm_done) begin
                    n_state = S_ETEST;
                end
            end
            S_DMUL: begin
                if (i_sts.mm_done) begin
                    n_state = S_DFIN;
                end
            end
            S_DFIN: begin
                if (i_mode == MODE_DEC && !i_sts.prod_byte) begin
                    n_err  = ERR_BYTE;
                    n_osel = OSEL_ZERO;
                end else begin
                    n_err  = ERR_OK;
                    n_osel = OSEL_PROD;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || i_m_tready) begin
                    o_cmd.out_ld = 1'b1;
                    n_ovalid     = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_ENC0;
            r_func      <= FUNC_START;
            r_key_ready <= 1'b0;
            r_ovalid    <= 1'b0;
            r_err       <= ERR_OK;
            r_osel      <= OSEL_ZERO;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_func      <= n_func;
            r_key_ready <= n_key_ready;
            r_ovalid    <= n_ovalid;
            r_err       <= n_err;
            r_osel      <= n_osel;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;

`ifndef NO_ASSERTIONS
    a_go_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mm_go |-> !i_sts.mm_busy)
        else $error("multiply started while the unit is busy");

    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.mm_done |=> !i_sts.mm_busy)
        else $error("multiply unit still busy after its last step");

    a_key_marks_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.key_ld |=> r_key_ready)
        else $error("message key stored without being marked ready");

    a_start_errors: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_ld && r_func == FUNC_START) |->
            (o_cmd.out_err == ERR_OK || o_cmd.out_err == ERR_KEY))
        else $error("start word reported a data error");
`endif

endmodule

/* src/elgamal_byte_cipher.sv */
// Data word: unless refused with an error, the result follows one 32-step modular multiply.
// Start word: up to three 32-bit modular exponentiations by square-and-multiply in encrypt
// mode and one in decrypt mode; a key error is answered without any exponentiation.
// One word is worked on at a time; the next is taken once the result sits in the output register.
// Synchronous active-low reset restores the register defaults and discards any message key.
module elgamal_byte_cipher import ebc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_AW-1:0]      paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [VW-1:0]          i_s_tdata,   // value
    input  logic [0:0]             i_s_tuser,   // func
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata    // result_value, error_code, zero fill
);

    t_mode         r_mode;
    logic [VW-1:0] r_p;
    logic [VW-1:0] r_g;
    logic [VW-1:0] r_a;
    logic [VW-1:0] r_k;

    t_cfg          w_cfg;
    t_cmd          w_cmd;
    t_sts          w_sts;
    logic [VW-1:0] w_out_value;
    t_err          w_out_err;
    logic          w_wr;
    t_reg          w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg'(paddr[APB_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ENC;
            r_p    <= P_RESET;
            r_g    <= G_RESET;
            r_a    <= A_RESET;
            r_k    <= K_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MODE:  r_mode <= t_mode'(pwdata[0]);
                REG_PRIME: r_p    <= pwdata[VW-1:0];
                REG_GEN:   r_g    <= pwdata[VW-1:0];
                REG_PKEY:  r_a    <= pwdata[VW-1:0];
                REG_SKEY:  r_k    <= pwdata[VW-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_MODE:  prdata = {{(APB_DW-1){1'b0}}, r_mode};
            REG_PRIME: prdata = APB_DW'(r_p);
            REG_GEN:   prdata = APB_DW'(r_g);
            REG_PKEY:  prdata = APB_DW'(r_a);
            REG_SKEY:  prdata = APB_DW'(r_k);
            default:   prdata = '0;
        endcase
    end

    assign w_cfg.mode = r_mode;
    assign w_cfg.p    = r_p;
    assign w_cfg.g    = r_g;
    assign w_cfg.a    = r_a;
    assign w_cfg.k    = r_k;

    ebc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (r_mode),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_func   (t_func'(i_s_tuser[0])),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ebc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_value     (i_s_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_value (w_out_value),
        .o_out_err   (w_out_err)
    );

    assign o_m_tdata = {{(OUT_TDATA_W - VW - ERR_W){1'b0}}, w_out_err, w_out_value};

endmodule
